/* hdl/ssk_pkg.sv */
// ----------------------------------------------------------------------------
// ssk_pkg
// Types and constants shared by the Shell sort core with Knuth gaps.
// ----------------------------------------------------------------------------
package ssk_pkg;

    localparam int unsigned VALUE_W = 32;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } item_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      last_out;
        logic                      overflow;
    } result_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_GAP_FIRST,
        ST_GAP_NEXT,
        ST_PASS_I,
        ST_RD,
        ST_CMP,
        ST_WR2,
        ST_EMIT_RD,
        ST_EMIT_LD
    } sort_state_t;

endpackage

/* hdl/shell_sort_knuth_gaps_core.sv */
// ----------------------------------------------------------------------------
// shell_sort_knuth_gaps_core
// Collects a set of signed values, Shell-sorts them in place in one memory
// using Knuth gaps, then emits them in ascending order.
// ----------------------------------------------------------------------------
// Loading takes one item per cycle while item_stall is low; after the marked
// item the sort runs each compare-exchange step as read, compare with first
// write and second write, through the single store (one write port, two
// registered read ports); each result is emitted once the output is free.
// Reset clears the element count, the dropped flag and all control state;
// the store contents are undefined until written.
module shell_sort_knuth_gaps_core #(
    parameter int unsigned MAX_ITEMS = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  ssk_pkg::item_t  item,
    output logic            result_valid,
    input  logic            result_stall,
    output ssk_pkg::result_t result
);
    import ssk_pkg::*;

    localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
    localparam int unsigned XW = CW + 4;

    logic [VALUE_W-1:0] mem [MAX_ITEMS];

    sort_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          dropped_reg, dropped_next;
    logic [CW-1:0] gap_reg, gap_next;
    logic [CW-1:0] cand_reg, cand_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] k_reg, k_next;
    result_t       result_reg, result_next;
    logic          result_valid_reg, result_valid_next;

    logic [VALUE_W-1:0] rd_a_reg, rd_b_reg;
    logic               rd_en;
    logic [AW-1:0]      raddr_a, raddr_b;
    logic               mem_we;
    logic [AW-1:0]      waddr;
    logic [VALUE_W-1:0] wdata;

    logic [CW-1:0] j_minus_gap;
    logic [XW-1:0] cand_x9p3;
    logic [XW-1:0] cand_x3p1;
    logic          out_taken;

    assign j_minus_gap = j_reg - gap_reg;
    assign cand_x9p3   = (XW'(cand_reg) << 3) + XW'(cand_reg) + XW'(3);
    assign cand_x3p1   = (XW'(cand_reg) << 1) + XW'(cand_reg) + XW'(1);
    assign out_taken   = result_valid_reg && !result_stall;

    assign item_stall   = (state_reg != ST_LOAD);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Store: one write port, two registered read ports.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rd_a_reg <= mem[raddr_a];
            rd_b_reg <= mem[raddr_b];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_LOAD;
            count_reg        <= '0;
            dropped_reg      <= 1'b0;
            gap_reg          <= '0;
            cand_reg         <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            k_reg            <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            dropped_reg      <= dropped_next;
            gap_reg          <= gap_next;
            cand_reg         <= cand_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            k_reg            <= k_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        dropped_next      = dropped_reg;
        gap_next          = gap_reg;
        cand_next         = cand_reg;
        i_next            = i_reg;
        j_next            = j_reg;
        k_next            = k_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && !out_taken;
        rd_en             = 1'b0;
        raddr_a           = j_minus_gap[AW-1:0];
        raddr_b           = j_reg[AW-1:0];
        mem_we            = 1'b0;
        waddr             = count_reg[AW-1:0];
        wdata             = item.value;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (item_valid)
                begin
                    if (count_reg < CW'(MAX_ITEMS))
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (item.last)
                    begin
                        cand_next  = CW'(1);
                        state_next = ST_GAP_FIRST;
                    end
                end
            end

            // The first gap is the largest Knuth gap h not above count/3 (at least 1),
            // found by testing 3*(3h+1) <= count, one gap step per cycle.
            ST_GAP_FIRST:
            begin
                if (cand_x9p3 <= XW'(count_reg))
                begin
                    cand_next = cand_x3p1[CW-1:0];
                end
                else
                begin
                    gap_next   = cand_reg;
                    i_next     = cand_reg;
                    state_next = ST_PASS_I;
                end
            end

            // The next gap is the largest Knuth gap below the current one.
            ST_GAP_NEXT:
            begin
                if (cand_x3p1 < XW'(gap_reg))
                begin
                    cand_next = cand_x3p1[CW-1:0];
                end
                else
                begin
                    gap_next   = cand_reg;
                    i_next     = cand_reg;
                    state_next = ST_PASS_I;
                end
            end

            ST_PASS_I:
            begin
                if (i_reg < count_reg)
                begin
                    j_next     = i_reg;
                    state_next = ST_RD;
                end
                else if (gap_reg == CW'(1))
                begin
                    k_next     = '0;
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    cand_next  = CW'(1);
                    state_next = ST_GAP_NEXT;
                end
            end

            ST_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_CMP;
            end

            // rd_a holds the entry at j-gap, rd_b the entry at j.
            ST_CMP:
            begin
                if ($signed(rd_a_reg) > $signed(rd_b_reg))
                begin
                    mem_we     = 1'b1;
                    waddr      = j_minus_gap[AW-1:0];
                    wdata      = rd_b_reg;
                    state_next = ST_WR2;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = ST_PASS_I;
                end
            end

            ST_WR2:
            begin
                mem_we = 1'b1;
                waddr  = j_reg[AW-1:0];
                wdata  = rd_a_reg;
                if (j_minus_gap >= gap_reg)
                begin
                    j_next     = j_minus_gap;
                    state_next = ST_RD;
                end
                else
                begin
                    i_next     = i_reg + CW'(1);
                    state_next = ST_PASS_I;
                end
            end

            ST_EMIT_RD:
            begin
                raddr_a = k_reg[AW-1:0];
                if (!result_valid_reg)
                begin
                    rd_en      = 1'b1;
                    state_next = ST_EMIT_LD;
                end
            end

            ST_EMIT_LD:
            begin
                result_next.sorted_value = rd_a_reg;
                result_next.last_out     = (k_reg == count_reg - CW'(1));
                result_next.overflow     = dropped_reg;
                result_valid_next        = 1'b1;
                if (k_reg == count_reg - CW'(1))
                begin
                    // The final item may wait at the output while a new set loads.
                    count_next   = '0;
                    dropped_next = 1'b0;
                    state_next   = ST_LOAD;
                end
                else
                begin
                    k_next     = k_reg + CW'(1);
                    state_next = ST_EMIT_RD;
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ITEMS))
        else $error("element count exceeds capacity");

    a_cmp_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CMP |-> $past(state_reg) == ST_RD)
        else $error("compare without a preceding read");

    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT_LD |-> !$past(result_valid_reg))
        else $error("result register overwritten while occupied");

endmodule

/* sim/shell_sort_knuth_gaps_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shell_sort_knuth_gaps_core_tb
// Sends sets of signed values to the Shell sort core and checks that each
// set comes back in ascending order, with the final flag and the overflow
// flag. The expected output comes from a predictor that keeps its own store
// and applies the same gap sequence.
// ----------------------------------------------------------------------------
module shell_sort_knuth_gaps_core_tb;

    import ssk_pkg::*;

    localparam int unsigned STORE_DEPTH = 64;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef enum int {SPREAD_NARROW, SPREAD_EDGES, SPREAD_FULL} spread_t;

    logic    clk = 1'b0;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    // Predictor state: the values of the set being collected.
    logic signed [VALUE_W-1:0] held_values [STORE_DEPTH];
    int unsigned               held_count = 0;
    logic                      held_dropped = 1'b0;

    result_t sorted_q [$];
    result_t want;
    int      fail_count = 0;
    int      send_idle_pct = 0;
    int      stall_pct = 0;

    shell_sort_knuth_gaps_core #(
        .MAX_ITEMS(STORE_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item(item),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        result_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (sorted_q.size() == 0)
            begin
                $display("%0t: unexpected result, got value %0d last %0b overflow %0b",
                         $time, result.sorted_value, result.last_out, result.overflow);
                fail_count++;
            end
            else
            begin
                want = sorted_q.pop_front();
                if (result.sorted_value !== want.sorted_value)
                begin
                    $display("%0t: sorted_value expected %0d, got %0d",
                             $time, want.sorted_value, result.sorted_value);
                    fail_count++;
                end
                if (result.last_out !== want.last_out)
                begin
                    $display("%0t: last_out expected %0b, got %0b",
                             $time, want.last_out, result.last_out);
                    fail_count++;
                end
                if (result.overflow !== want.overflow)
                begin
                    $display("%0t: overflow expected %0b, got %0b",
                             $time, want.overflow, result.overflow);
                    fail_count++;
                end
            end
        end
    end

    // In-place Shell sort of the held set with gaps 1, 4, 13, 40 and so on.
    task automatic shell_sort_held();
        int unsigned gap;
        int          i;
        int          j;
        logic signed [VALUE_W-1:0] lo;
        logic signed [VALUE_W-1:0] hi;
        gap = 1;
        while (3 * gap + 1 <= held_count / 3)
            gap = 3 * gap + 1;
        while (gap >= 1)
        begin
            for (i = gap; i < held_count; i++)
            begin
                for (j = i; j >= gap; j -= gap)
                begin
                    lo = held_values[j - gap];
                    hi = held_values[j];
                    if (lo > hi)
                    begin
                        held_values[j - gap] = hi;
                        held_values[j] = lo;
                    end
                end
            end
            gap = gap / 3;
        end
    endtask

    // Called for each accepted item; a marked item closes the set.
    task automatic absorb_item(input logic signed [VALUE_W-1:0] v, input logic lst);
        result_t r;
        int      k;
        if (held_count < STORE_DEPTH)
        begin
            held_values[held_count] = v;
            held_count++;
        end
        else
            held_dropped = 1'b1;
        if (lst)
        begin
            shell_sort_held();
            for (k = 0; k < held_count; k++)
            begin
                r.sorted_value = held_values[k];
                r.last_out = (k + 1 == held_count);
                r.overflow = held_dropped;
                sorted_q.push_back(r);
            end
            held_count = 0;
            held_dropped = 1'b0;
        end
    endtask

    task automatic push_item(input logic signed [VALUE_W-1:0] v, input logic lst);
        item_t next_item;
        next_item.value = v;
        next_item.last = lst;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= next_item;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        absorb_item(v, lst);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        item_valid <= 1'b0;
        while (sorted_q.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value(input spread_t spread);
        case (spread)
            SPREAD_NARROW: return $urandom_range(8) - 4;
            SPREAD_EDGES:
            begin
                case ($urandom_range(4))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return 0;
                    3: return -1;
                    default: return 1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic test_single_items();
        push_item(VAL_MAX, 1'b1);
        push_item(VAL_MIN, 1'b1);
        push_item(VAL_MAX, 1'b0);
        push_item(VAL_MIN, 1'b1);
    endtask

    task automatic test_extremes();
        push_item(0, 1'b0);
        push_item(-1, 1'b0);
        push_item(1, 1'b0);
        push_item(VAL_MIN, 1'b0);
        push_item(VAL_MAX, 1'b0);
        push_item(VAL_MAX, 1'b0);
        push_item(VAL_MIN, 1'b0);
        push_item(-1, 1'b1);
    endtask

    // Twelve values are the smallest set whose first gap is four.
    task automatic test_gap_four();
        int k;
        for (k = 0; k < 12; k++)
            push_item(6 - k, k == 11);
    endtask

    // A set that fills the store exactly, then one whose last two items,
    // the marked one among them, are dropped.
    task automatic test_store_full();
        int k;
        for (k = 0; k < STORE_DEPTH; k++)
            push_item(pick_value(SPREAD_FULL), k == STORE_DEPTH - 1);
        for (k = 0; k < STORE_DEPTH + 2; k++)
            push_item(pick_value(SPREAD_NARROW), k == STORE_DEPTH + 1);
    endtask

    task automatic test_random_sets(input int target);
        int      sent;
        int      set_size;
        int      k;
        spread_t spread;
        sent = 0;
        while (sent < target)
        begin
            if ($urandom_range(7) == 0)
                set_size = $urandom_range(40, 11);
            else
                set_size = $urandom_range(10, 1);
            spread = spread_t'($urandom_range(2));
            for (k = 0; k < set_size; k++)
                push_item(pick_value(spread), k == set_size - 1);
            sent += set_size;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 26;
        stall_pct = 70;
        test_single_items();
        test_extremes();
        test_gap_four();
        test_random_sets(30);
        // Hold the input off until the core has emitted everything.
        wait_drained();

        send_idle_pct = 70;
        stall_pct = 26;
        test_store_full();
        test_random_sets(30);

        send_idle_pct = 0;
        stall_pct = 0;
        test_random_sets(40);

        wait_drained();
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
hdl/ssk_pkg.sv
hdl/shell_sort_knuth_gaps_core.sv
sim/shell_sort_knuth_gaps_core_tb.sv
